// ===== sv/srd_pkg.sv =====
// ----------------------------------------------------------------------------
// srd_pkg: shared types and constants for the signed restoring divider
// Holds the per-transaction flag struct and the depth of the queue that
// parts the operand front end from the division array.
// ----------------------------------------------------------------------------
package srd_pkg;

  // entries in the queue between front end and division array
  localparam int unsigned QUEUE_DEPTH = 2;

  // classification of one transaction, set by the front end
  typedef struct packed {
    logic negate;    // operand signs differ, quotient is negated
    logic div_zero;  // divisor is zero, quotient forced to zero
  } srd_flags_t;

  localparam int unsigned FLAGS_W = $bits(srd_flags_t);

endpackage

// ===== sv/signed_restoring_divider.sv =====
// ----------------------------------------------------------------------------
// signed_restoring_divider: pipelined signed integer divider
// Divides a signed dividend by a signed divisor, quotient truncated toward
// zero; a zero divisor gives quotient 0 and raises divide_by_zero.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  in_valid/in_ready carries dividend and divisor; a
//   transaction is taken at a clock edge with both high.
//   output channel out_valid/out_ready carries quotient and divide_by_zero.
//   path: the operand queue, the stage-zero operand load, one subtract stage
//   per quotient bit in the array, then the output register.
//   throughput: one transaction per cycle unless a waiting result is held by
//   out_ready low; each array stage holds a single DATA_WIDTH + 1 bit subtract.
//   the most negative dividend over minus one wraps to the most negative value.
//   reset clears the queue and all stage valid bits; in_ready is low while
//   reset is held and high in the first cycle after it is released.
//   when a result waits with out_ready low the array and output register
//   hold; the queue keeps taking transactions until its QUEUE_DEPTH entries
//   are full, then in_ready drops.
// ----------------------------------------------------------------------------
module signed_restoring_divider #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] dividend,
  input  logic signed [DATA_WIDTH-1:0] divisor,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] quotient,
  output logic                         divide_by_zero
);
  import srd_pkg::*;

  localparam int unsigned ENTRY_W = 2 * DATA_WIDTH + FLAGS_W;

  logic [DATA_WIDTH-1:0] front_num;
  logic [DATA_WIDTH-1:0] front_den;
  srd_flags_t            front_flags;
  logic [ENTRY_W-1:0]    push_data;
  logic [ENTRY_W-1:0]    pop_data;
  logic                  pop_valid;
  logic                  pop_ready;
  srd_flags_t            head_flags;

  // operand classification
  srd_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .dividend (dividend),
    .divisor  (divisor),
    .num_mag  (front_num),
    .den_mag  (front_den),
    .flags    (front_flags)
  );

  assign push_data = {front_flags, front_num, front_den};

  // queue between front end and array
  srd_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign head_flags = pop_data[ENTRY_W-1 -: FLAGS_W];

  // division array and output register
  srd_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (pop_valid),
    .in_ready       (pop_ready),
    .num_mag        (pop_data[2*DATA_WIDTH-1 -: DATA_WIDTH]),
    .den_mag        (pop_data[DATA_WIDTH-1:0]),
    .flags          (head_flags),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .quotient       (quotient),
    .divide_by_zero (divide_by_zero)
  );

endmodule

// ===== sv/srd_front.sv =====
// ----------------------------------------------------------------------------
// srd_front: operand classification
// Forms the magnitudes of dividend and divisor and flags the sign of the
// result and a zero divisor.
// ----------------------------------------------------------------------------
module srd_front #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic signed [DATA_WIDTH-1:0] dividend,
  input  logic signed [DATA_WIDTH-1:0] divisor,
  output logic        [DATA_WIDTH-1:0] num_mag,
  output logic        [DATA_WIDTH-1:0] den_mag,
  output srd_pkg::srd_flags_t          flags
);
  import srd_pkg::*;

  // magnitudes; the most negative value maps to 2^(DATA_WIDTH-1) unsigned
  assign num_mag = dividend[DATA_WIDTH-1] ? ({DATA_WIDTH{1'b0}} - dividend) : dividend;
  assign den_mag = divisor[DATA_WIDTH-1]  ? ({DATA_WIDTH{1'b0}} - divisor)  : divisor;

  // result sign and zero divisor
  always_comb begin
    flags.negate   = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
    flags.div_zero = (divisor == {DATA_WIDTH{1'b0}});
  end

endmodule

// ===== sv/srd_queue.sv =====
// ----------------------------------------------------------------------------
// srd_queue: small register queue
// Holds classified transactions between the front end and the division
// array so that each side can stall on its own.
// ----------------------------------------------------------------------------
module srd_queue #(
  parameter int unsigned WIDTH = 66,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import srd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_fire;
  logic             pop_fire;

  // handshake; nothing is taken while reset is held
  assign push_ready = !rst && (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != {CNT_W{1'b0}});
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;
  assign pop_data   = entry[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push_fire) begin
      entry[wr_ptr] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  // fill count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

  // a lone push raises the count by one
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    push_fire && !pop_fire |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow push");
`endif

endmodule

// ===== sv/srd_back.sv =====
// ----------------------------------------------------------------------------
// srd_back: pipelined restoring division array
// Stage zero loads the operands, then one shift-subtract stage per quotient bit,
// msb first, then an output register that applies the sign and the zero-divisor case.
// ----------------------------------------------------------------------------
module srd_back #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic        [DATA_WIDTH-1:0] num_mag,
  input  logic        [DATA_WIDTH-1:0] den_mag,
  input  srd_pkg::srd_flags_t          flags,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] quotient,
  output logic                         divide_by_zero
);
  import srd_pkg::*;

  localparam int unsigned W = DATA_WIDTH;

  logic [W:0]   stg_valid;
  logic [W-1:0] stg_rem   [0:W];
  logic [W-1:0] stg_num   [0:W];
  logic [W-1:0] stg_quo   [0:W];
  logic [W-1:0] stg_den   [0:W];
  srd_flags_t   stg_flags [0:W];
  logic         advance;
  logic [W-1:0] result;

  // whole array moves when the output register can take a transaction
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= '0;
    end else if (advance) begin
      stg_valid <= {stg_valid[W-1:0], in_valid};
    end
  end

  // stage zero: load operands with a cleared partial remainder
  always_ff @(posedge clk) begin
    if (advance) begin
      stg_rem[0]   <= '0;
      stg_num[0]   <= num_mag;
      stg_quo[0]   <= '0;
      stg_den[0]   <= den_mag;
      stg_flags[0] <= flags;
    end
  end

  // one restoring step per stage
  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W:0]   shifted;
    logic [W:0]   diff;
    logic         take;

    assign shifted = {stg_rem[k], stg_num[k][W-1]};
    assign diff    = shifted - {1'b0, stg_den[k]};
    assign take    = !diff[W];

    always_ff @(posedge clk) begin
      if (advance) begin
        stg_rem[k+1]   <= take ? diff[W-1:0] : shifted[W-1:0];
        stg_num[k+1]   <= {stg_num[k][W-2:0], 1'b0};
        stg_quo[k+1]   <= {stg_quo[k][W-2:0], take};
        stg_den[k+1]   <= stg_den[k];
        stg_flags[k+1] <= stg_flags[k];
      end
    end
  end

  // sign fix-up and zero divisor override
  always_comb begin
    if (stg_flags[W].div_zero) begin
      result = '0;
    end else if (stg_flags[W].negate) begin
      result = {W{1'b0}} - stg_quo[W];
    end else begin
      result = stg_quo[W];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stg_valid[W];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      quotient       <= result;
      divide_by_zero <= stg_flags[W].div_zero;
    end
  end

`ifndef NO_ASSERTIONS
  // a zero divisor always reports a zero quotient
  a_dbz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> quotient == '0)
    else $error("divide by zero with nonzero quotient");

  // a finished transaction stays in the last stage while output stalls
  a_last_hold: assert property (@(posedge clk) disable iff (rst)
    stg_valid[W] && !advance |=> stg_valid[W])
    else $error("last stage lost a transaction during stall");

  // an accepted transaction enters stage zero
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> stg_valid[0])
    else $error("accepted transaction missing from stage zero");
`endif

endmodule

// ===== tb/sv/quotient_checker.sv =====
// ----------------------------------------------------------------------------
// quotient_checker: scoreboard for the signed restoring divider
// Watches both channels of the divider. Every input transaction is divided
// by a shift-subtract predictor of its own. Every output transaction is
// compared field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module quotient_checker #(
  parameter int unsigned W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic signed [W-1:0] dividend,
  input  logic signed [W-1:0] divisor,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic signed [W-1:0] quotient,
  input  logic                divide_by_zero,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic [W-1:0] quotient;
    logic         divide_by_zero;
  } division_result_t;

  division_result_t expected_quotients[$];

  // magnitudes, one restoring step per bit from the msb, then sign fix-up
  function automatic division_result_t divide_signed(logic [W-1:0] num, logic [W-1:0] den);
    division_result_t res;
    logic [W-1:0]     mag_num;
    logic [W-1:0]     mag_den;
    logic [W:0]       partial;
    res.quotient       = '0;
    res.divide_by_zero = 1'b0;
    if (den == '0) begin
      res.divide_by_zero = 1'b1;
      return res;
    end
    mag_num = num[W-1] ? -num : num;
    mag_den = den[W-1] ? -den : den;
    partial = '0;
    for (int i = W - 1; i >= 0; i--) begin
      partial = {partial[W-1:0], mag_num[i]};
      if (partial >= {1'b0, mag_den}) begin
        partial        = partial - {1'b0, mag_den};
        res.quotient[i] = 1'b1;
      end
    end
    // most negative over minus one wraps here by itself
    if (num[W-1] ^ den[W-1]) begin
      res.quotient = -res.quotient;
    end
    return res;
  endfunction

  // values seen here are the ones present at the rising edge
  always @(posedge clk) begin
    division_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_quotients.push_back(divide_signed(dividend, divisor));
      end
      if (out_valid && out_ready) begin
        if (expected_quotients.size() == 0) begin
          $display("%0t unexpected result: quotient %0d divide_by_zero %0b",
                   $time, quotient, divide_by_zero);
          fail_count++;
        end else begin
          want = expected_quotients.pop_front();
          if (quotient !== want.quotient) begin
            $display("%0t quotient mismatch: expected %0d actual %0d",
                     $time, $signed(want.quotient), quotient);
            fail_count++;
          end
          if (divide_by_zero !== want.divide_by_zero) begin
            $display("%0t divide_by_zero mismatch: expected %0b actual %0b",
                     $time, want.divide_by_zero, divide_by_zero);
            fail_count++;
          end
        end
      end
      pending = expected_quotients.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the signed restoring divider
// Drives directed corner divisions, then randomized ones, with random gaps
// on both channels and one long output hold-off that fills the divider.
// The quotient checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned W             = 32;
  localparam int          RANDOM_ITEMS  = 1130;
  localparam int          IDLE_LIMIT    = 2000;
  localparam int          DRAIN_CYCLES  = 60;
  localparam int          HOLD_AT       = 120;
  localparam int          HOLD_CYCLES   = 200;

  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINUS_ONE = '1;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic signed [W-1:0] dividend;
  logic signed [W-1:0] divisor;
  logic                out_valid;
  logic                out_ready;
  logic signed [W-1:0] quotient;
  logic                divide_by_zero;
  int                  fail_count;
  int                  pending;
  int                  idle_cycles;
  bit                  send_burst;
  bit                  recv_burst;

  signed_restoring_divider #(.DATA_WIDTH(W)) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .dividend       (dividend),
    .divisor        (divisor),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .quotient       (quotient),
    .divide_by_zero (divide_by_zero)
  );

  quotient_checker #(.W(W)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .dividend       (dividend),
    .divisor        (divisor),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .quotient       (quotient),
    .divide_by_zero (divide_by_zero),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one division, called at a falling edge, returns at a falling edge
  task automatic send_division(input logic [W-1:0] num, input logic [W-1:0] den);
    int gap;
    if ($urandom_range(0, 19) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    dividend = num;
    divisor  = den;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // a random value of random magnitude and sign
  function automatic logic [W-1:0] scaled_operand();
    logic [W-1:0] v;
    v = $urandom;
    v = v >> $urandom_range(0, W - 1);
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // receiver: random stalls, bursts, and one long hold-off
  initial begin
    int stall;
    int results;
    results    = 0;
    recv_burst = 1'b0;
    out_ready  = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) recv_burst = ~recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 4);
      if (results == HOLD_AT) stall = HOLD_CYCLES;
      repeat (stall) begin
        out_ready = 1'b0;
        @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      results++;
      @(negedge clk);
    end
  end

  // reset, stimulus and verdict
  initial begin
    logic [W-1:0] num;
    logic [W-1:0] den;
    rst        = 1'b1;
    in_valid   = 1'b0;
    dividend   = '0;
    divisor    = '0;
    send_burst = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // corner divisions: overflow wrap, zero divisor, sign combinations
    send_division(MOST_NEG, MINUS_ONE);
    send_division(MOST_NEG, 1);
    send_division(MOST_NEG, MOST_NEG);
    send_division(MOST_POS, MOST_NEG);
    send_division(MOST_POS, MINUS_ONE);
    send_division(MOST_POS, MOST_POS);
    send_division(MOST_POS, 1);
    send_division(0, 0);
    send_division(5, 0);
    send_division(MOST_NEG, 0);
    send_division(MOST_POS, 0);
    send_division(MINUS_ONE, 0);
    send_division(7, 2);
    send_division(-7, 2);
    send_division(7, -2);
    send_division(-7, -2);
    send_division(0, 5);
    send_division(1, MOST_POS);
    send_division(MINUS_ONE, MINUS_ONE);
    send_division(MINUS_ONE, 1);
    send_division(1, MINUS_ONE);
    send_division(MOST_NEG, 2);
    send_division(100, 7);
    send_division(3, 5);

    // randomized divisions across operand shapes
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      num = $urandom;
      den = $urandom;
      case ($urandom_range(0, 9))
        0: den = '0;
        1: den = $urandom_range(0, 32) - 16;
        2: num = $urandom_range(0, 1) ? MOST_NEG : MOST_POS;
        3: den = $urandom_range(0, 1) ? MINUS_ONE : 1;
        4: den = scaled_operand();
        5: begin
          num = scaled_operand();
          den = scaled_operand();
        end
        default: ;
      endcase
      send_division(num, den);
    end
    in_valid = 1'b0;

    // drain, then settle
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/srd_pkg.sv
sv/srd_front.sv
sv/srd_queue.sv
sv/srd_back.sv
sv/signed_restoring_divider.sv
tb/sv/quotient_checker.sv
tb/sv/tb_top.sv
